>>> rtl/mma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mma_pkg;

   localparam int SUM_W      = 48;
   localparam int TOTAL_W    = 36;
   localparam int PROD_W     = 34;
   localparam int DIV_STEPS  = 63;
   localparam int SQ_STEPS   = 48;
   localparam int SQRT_STEPS = 49;
   localparam int CNT_W      = 6;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_TRIAL  = 2'd1;
   localparam logic [1:0] MODE_COMMIT = 2'd2;
   localparam logic [1:0] MODE_READ   = 2'd3;

   localparam logic [2:0] COMP_X    = 3'd0;
   localparam logic [2:0] COMP_Y    = 3'd1;
   localparam logic [2:0] COMP_Z    = 3'd2;
   localparam logic [2:0] COMP_FULL = 3'd3;
   localparam logic [2:0] COMP_XY   = 3'd4;

   localparam logic [1:0] REG_MATERIAL  = 2'd0;
   localparam logic [1:0] REG_ALL       = 2'd1;
   localparam logic [1:0] REG_NORMALIZE = 2'd2;
   localparam logic [1:0] REG_COMPONENT = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic               first;
      logic [7:0]         species;
      logic [15:0]        moment;
      logic signed [15:0] spin_x;
      logic signed [15:0] spin_y;
      logic signed [15:0] spin_z;
      logic signed [15:0] trial_x;
      logic signed [15:0] trial_y;
      logic signed [15:0] trial_z;
   } mma_req_type;

   typedef struct packed {
      logic signed [47:0] cv_value;
      logic               status;
   } mma_rsp_type;

   typedef struct packed {
      logic [7:0] material_select;
      logic       all_materials;
      logic       normalize;
      logic [2:0] component;
   } mma_cfg_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_MUL, OP_UPDATE, OP_DIV_START, OP_DIV_STEP, OP_DIV_END,
      OP_SQ_START, OP_SQ_STEP, OP_SQRT_START, OP_SQRT_STEP, OP_SQRT_END, OP_OUT
   } mma_op_type;

   typedef struct packed {
      mma_op_type op;
      logic [1:0] idx;
      logic       clear;
   } mma_cmd_type;

   typedef struct packed {
      logic zero_div;
      logic out_busy;
   } mma_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_UPDATE, ST_DECIDE, ST_DIV_START, ST_DIV_STEP, ST_DIV_END,
      ST_SQ_START, ST_SQ_STEP, ST_SQRT_START, ST_SQRT_STEP, ST_SQRT_END, ST_FINISH
   } mma_state_type;

endpackage
`default_nettype wire

>>> rtl/mma_csr.sv
`timescale 1ns / 1ps
`default_nettype none
module mma_csr
   import mma_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output mma_cfg_type      cfg
);

   mma_cfg_type cfg_ff, cfg_in;
   logic        wr;

   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_paddr[3:2])
            REG_MATERIAL:  cfg_in.material_select = csr_pwdata[7:0];
            REG_ALL:       cfg_in.all_materials   = csr_pwdata[0];
            REG_NORMALIZE: cfg_in.normalize       = csr_pwdata[0];
            REG_COMPONENT: cfg_in.component       = csr_pwdata[2:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_MATERIAL:  csr_prdata = {24'd0, cfg_ff.material_select};
         REG_ALL:       csr_prdata = {31'd0, cfg_ff.all_materials};
         REG_NORMALIZE: csr_prdata = {31'd0, cfg_ff.normalize};
         REG_COMPONENT: csr_prdata = {29'd0, cfg_ff.component};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{material_select: 8'd0, all_materials: 1'b1, normalize: 1'b1,
                     component: COMP_Z};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/mma_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mma_datapath
   import mma_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mma_cfg_type cfg,
   input  wire mma_cmd_type cmd,
   input  wire mma_req_type req_data,
   input  wire logic        rsp_stall,
   output logic             rsp_valid,
   output mma_rsp_type      rsp_data,
   output mma_stat_type     stat
);

   localparam logic signed [SUM_W-1:0] S_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] S_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   mma_req_type               in_ff;
   logic signed [SUM_W-1:0]   sum_ff [3];
   logic signed [SUM_W-1:0]   sum_in [3];
   logic signed [SUM_W-1:0]   pend_ff [3];
   logic signed [SUM_W-1:0]   pend_in [3];
   logic signed [SUM_W-1:0]   eval_ff [3];
   logic signed [SUM_W-1:0]   eval_in [3];
   logic signed [PROD_W-1:0]  prod_ff [3];
   logic signed [PROD_W-1:0]  prod_in [3];
   logic [TOTAL_W-1:0]        total_ff, total_in;
   logic                      pvalid_ff, pvalid_in;
   logic [62:0]               dq_ff, dq_in;
   logic [TOTAL_W-1:0]        rem_ff, rem_in;
   logic                      neg_ff, neg_in;
   logic [95:0]               mcand_ff, mcand_in;
   logic [47:0]               mplier_ff, mplier_in;
   logic [97:0]               acc_ff, acc_in;
   logic [97:0]               rad_ff, rad_in;
   logic [48:0]               root_ff, root_in;
   logic [50:0]               srem_ff, srem_in;
   logic [47:0]               mag_ff, mag_in;
   mma_rsp_type               rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                      sel;
   logic signed [16:0]        mu;
   logic signed [16:0]        spin [3];
   logic signed [16:0]        trial [3];
   logic signed [SUM_W-1:0]   base [3];
   logic signed [SUM_W-1:0]   shifted [3];
   logic signed [SUM_W:0]     wide [3];
   logic [TOTAL_W-1:0]        tbase;
   logic [TOTAL_W:0]          twide;
   logic signed [SUM_W-1:0]   cur;
   logic [SUM_W-1:0]          cur_abs;
   logic [TOTAL_W:0]          r2;
   logic                      ge;
   logic [52:0]               rem2, trial_root;
   logic                      sge;

   assign sel = cfg.all_materials || (in_ff.species == cfg.material_select);
   assign mu = $signed({1'b0, in_ff.moment});
   assign spin[0] = 17'(in_ff.spin_x);
   assign spin[1] = 17'(in_ff.spin_y);
   assign spin[2] = 17'(in_ff.spin_z);
   assign trial[0] = 17'(in_ff.trial_x);
   assign trial[1] = 17'(in_ff.trial_y);
   assign trial[2] = 17'(in_ff.trial_z);
   assign cur = eval_ff[cmd.idx];
   assign cur_abs = cur[SUM_W-1] ? (~cur + 1'b1) : cur;
   assign r2 = {rem_ff, dq_ff[62]};
   assign ge = r2 >= {1'b0, total_ff};
   assign rem2 = {srem_ff, rad_ff[97:96]};
   assign trial_root = {2'b00, root_ff, 2'b01};
   assign sge = rem2 >= trial_root;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         base[k] = (in_ff.mode == MODE_LOAD && in_ff.first) ? '0 : sum_ff[k];
         wide[k] = {base[k][SUM_W-1], base[k]} + (SUM_W+1)'(prod_ff[k]);
         if (wide[k] > (SUM_W+1)'(S_MAX)) begin
            shifted[k] = S_MAX;
         end else if (wide[k] < $signed({S_MIN[SUM_W-1], S_MIN})) begin
            shifted[k] = S_MIN;
         end else begin
            shifted[k] = wide[k][SUM_W-1:0];
         end
      end
      tbase = (in_ff.first) ? '0 : total_ff;
      twide = {1'b0, tbase} + (TOTAL_W+1)'(in_ff.moment);
   end

   always_comb begin
      total_in = total_ff;
      pvalid_in = pvalid_ff;
      dq_in = dq_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      acc_in = acc_ff;
      rad_in = rad_ff;
      root_in = root_ff;
      srem_in = srem_ff;
      mag_in = mag_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      for (int k = 0; k < 3; k++) begin
         sum_in[k] = sum_ff[k];
         pend_in[k] = pend_ff[k];
         eval_in[k] = eval_ff[k];
         prod_in[k] = prod_ff[k];
      end
      case (cmd.op)
         OP_MUL: begin
            for (int k = 0; k < 3; k++) begin
               if (in_ff.mode == MODE_LOAD) begin
                  prod_in[k] = PROD_W'(mu * spin[k]);
               end else begin
                  prod_in[k] = PROD_W'(mu * (trial[k] - spin[k]));
               end
            end
         end
         OP_UPDATE: begin
            case (in_ff.mode)
               MODE_LOAD: begin
                  pvalid_in = 1'b0;
                  if (sel) begin
                     total_in = twide[TOTAL_W] ? {TOTAL_W{1'b1}} : twide[TOTAL_W-1:0];
                  end else begin
                     total_in = tbase;
                  end
                  for (int k = 0; k < 3; k++) begin
                     sum_in[k] = sel ? shifted[k] : base[k];
                     eval_in[k] = sum_in[k];
                  end
               end
               MODE_TRIAL: begin
                  pvalid_in = 1'b1;
                  for (int k = 0; k < 3; k++) begin
                     pend_in[k] = sel ? shifted[k] : sum_ff[k];
                     eval_in[k] = pend_in[k];
                  end
               end
               MODE_COMMIT: begin
                  pvalid_in = 1'b0;
                  for (int k = 0; k < 3; k++) begin
                     sum_in[k] = pvalid_ff ? pend_ff[k] : sum_ff[k];
                     eval_in[k] = sum_in[k];
                  end
               end
               default: begin
                  for (int k = 0; k < 3; k++) begin
                     eval_in[k] = sum_ff[k];
                  end
               end
            endcase
         end
         OP_DIV_START: begin
            dq_in = {cur_abs, 15'd0};
            rem_in = '0;
            neg_in = cur[SUM_W-1];
         end
         OP_DIV_STEP: begin
            rem_in = ge ? TOTAL_W'(r2 - {1'b0, total_ff}) : r2[TOTAL_W-1:0];
            dq_in = {dq_ff[61:0], ge};
         end
         OP_DIV_END: begin
            if (neg_ff) begin
               if (dq_ff > 63'(S_MIN) && dq_ff != 63'({1'b0, S_MIN})) begin
                  eval_in[cmd.idx] = S_MIN;
               end else if (dq_ff > 63'({1'b0, S_MIN})) begin
                  eval_in[cmd.idx] = S_MIN;
               end else begin
                  eval_in[cmd.idx] = ~dq_ff[SUM_W-1:0] + 1'b1;
               end
            end else begin
               eval_in[cmd.idx] = (dq_ff > 63'(S_MAX)) ? S_MAX : dq_ff[SUM_W-1:0];
            end
         end
         OP_SQ_START: begin
            mcand_in = {48'd0, cur_abs};
            mplier_in = cur_abs;
            if (cmd.clear) begin
               acc_in = '0;
            end
         end
         OP_SQ_STEP: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + {2'b00, mcand_ff};
            end
            mcand_in = {mcand_ff[94:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[47:1]};
         end
         OP_SQRT_START: begin
            rad_in = acc_ff;
            root_in = '0;
            srem_in = '0;
         end
         OP_SQRT_STEP: begin
            srem_in = sge ? 51'(rem2 - trial_root) : rem2[50:0];
            root_in = {root_ff[47:0], sge};
            rad_in = {rad_ff[95:0], 2'b00};
         end
         OP_SQRT_END: begin
            mag_in = (root_ff > 49'(S_MAX)) ? 48'(S_MAX) : root_ff[47:0];
         end
         OP_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_in.status = 1'b0;
            if (stat.zero_div) begin
               rsp_in.status = 1'b1;
               rsp_in.cv_value = '0;
            end else begin
               case (cfg.component) inside
                  COMP_X:             rsp_in.cv_value = eval_ff[0];
                  COMP_Y:             rsp_in.cv_value = eval_ff[1];
                  COMP_Z:             rsp_in.cv_value = eval_ff[2];
                  COMP_FULL, COMP_XY: rsp_in.cv_value = $signed(mag_ff);
                  default:            rsp_in.cv_value = '0;
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   assign stat.zero_div = cfg.normalize && (total_ff == '0);
   assign stat.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         pvalid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= '0;
            pend_ff[k] <= '0;
         end
      end else begin
         total_ff <= total_in;
         pvalid_ff <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= sum_in[k];
            pend_ff[k] <= pend_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         in_ff <= req_data;
      end
      for (int k = 0; k < 3; k++) begin
         eval_ff[k] <= eval_in[k];
         prod_ff[k] <= prod_in[k];
      end
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff <= acc_in;
      rad_ff <= rad_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
      mag_ff <= mag_in;
      rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

>>> rtl/mma_controller.sv
`timescale 1ns / 1ps
`default_nettype none
module mma_controller
   import mma_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire mma_cfg_type  cfg,
   input  wire mma_stat_type stat,
   input  wire logic         req_valid,
   output logic              req_stall,
   output mma_cmd_type       cmd
);

   mma_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       idx_ff, idx_in;
   logic             mag;
   logic [1:0]       last_sq;

   assign mag = (cfg.component == COMP_FULL) || (cfg.component == COMP_XY);
   assign last_sq = (cfg.component == COMP_FULL) ? 2'd2 : 2'd1;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      cmd.op = OP_NONE;
      cmd.idx = idx_ff;
      cmd.clear = (idx_ff == 2'd0);
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.op = OP_MUL;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.op = OP_UPDATE;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            idx_in = 2'd0;
            if (stat.zero_div) begin
               state_in = ST_FINISH;
            end else if (cfg.normalize) begin
               state_in = ST_DIV_START;
            end else if (mag) begin
               state_in = ST_SQ_START;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV_START: begin
            cmd.op = OP_DIV_START;
            cnt_in = '0;
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            cmd.op = OP_DIV_END;
            if (idx_ff == 2'd2) begin
               idx_in = 2'd0;
               state_in = mag ? ST_SQ_START : ST_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_DIV_START;
            end
         end
         ST_SQ_START: begin
            cmd.op = OP_SQ_START;
            cnt_in = '0;
            state_in = ST_SQ_STEP;
         end
         ST_SQ_STEP: begin
            cmd.op = OP_SQ_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQ_STEPS - 1)) begin
               if (idx_ff == last_sq) begin
                  state_in = ST_SQRT_START;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = ST_SQ_START;
               end
            end
         end
         ST_SQRT_START: begin
            cmd.op = OP_SQRT_START;
            cnt_in = '0;
            state_in = ST_SQRT_STEP;
         end
         ST_SQRT_STEP: begin
            cmd.op = OP_SQRT_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               state_in = ST_SQRT_END;
            end
         end
         ST_SQRT_END: begin
            cmd.op = OP_SQRT_END;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!stat.out_busy) begin
               cmd.op = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/masked_magnetisation_accumulator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Ports                        Moves
// req       in         req_valid/req_stall/req_data one request per item
// rsp       out        rsp_valid/rsp_stall/rsp_data one result per request
// csr       in/out     csr_psel ... csr_pready      register access
//
// One request at a time: after acceptance it is multiplied, updated and the
// next step decided; when normalising, the bit-serial divider then runs once
// per component, and for magnitudes each component is squared and the bit-serial
// square root taken, before the result is loaded into the output register.
// Reset clears the sums, pending sums, total, pending flag, valid flag and CSRs.
// A result waits in the output register while rsp_stall is high; the next
// request is taken meanwhile and held before its own output until it drains.
module masked_magnetisation_accumulator_top
   import mma_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire mma_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output mma_rsp_type      rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   mma_cfg_type  cfg;
   mma_cmd_type  cmd;
   mma_stat_type stat;

   mma_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mma_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .stat      (stat)
   );

   mma_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .stat      (stat),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

endmodule
`default_nettype wire
